FILE: design/pnpt_pkg.sv
package pnpt_pkg;

	// Path storage sizing
	localparam int MAX_POINTS = 1024;
	localparam int IDX_W      = $clog2(MAX_POINTS);
	localparam int CNT_W      = $clog2(MAX_POINTS + 1);

	// Field widths
	localparam int POS_W  = 32;
	localparam int ANG_W  = 16;
	localparam int TOL_W  = 53;
	localparam int DIST_W = 2 * POS_W + 1;

	// Search start bound, 2^20 m^2 in Q.32
	localparam logic [TOL_W-1:0] SEARCH_BOUND = TOL_W'(1) << 52;
	localparam logic [TOL_W-1:0] TOL_RESET    = TOL_W'(42949673);

	// Stream widths
	localparam int POINT_W    = 2 * POS_W + 3 * ANG_W;
	localparam int S_TDATA_W  = POINT_W;
	localparam int M_TDATA_W  = ((POINT_W + IDX_W + 7) / 8) * 8;
	localparam int M_PAD_W    = M_TDATA_W - POINT_W - IDX_W;
	localparam int TUSER_W    = 2;

	// Input kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// One stored path point, x in the low bits
	typedef struct packed {
		logic signed [ANG_W-1:0] turn;
		logic signed [ANG_W-1:0] speed;
		logic signed [ANG_W-1:0] heading;
		logic signed [POS_W-1:0] y;
		logic signed [POS_W-1:0] x;
	} point_t;

	// Tag that travels with a distance calculation
	typedef struct packed {
		logic             valid;
		logic             is_end;
		logic [IDX_W-1:0] idx;
	} dist_tag_t;

	// Result load control from the sequencer to the output register
	typedef struct packed {
		logic             load;
		logic             no_path;
		logic             near_ends;
		logic [IDX_W-1:0] idx;
	} result_ctl_t;

endpackage

FILE: design/path_nearest_point_tracker_core.sv
// Forward nearest-point tracker for a stored reference path.
// Input stream (s_*): one transaction is either a path point load
// (s_tuser kind = 0) or a pose query (kind = 1). A load with start_new set
// clears the path and the match index before storing its point; loads past
// the path capacity are dropped. Loads give no result and leave s_tready high.
// A query walks the stored path from the current match index to the end,
// one point per cycle through the shared distance unit, and returns one
// result transaction on m_*: the matched point, its index, a no-path flag
// and a flag for first and last points lying within tolerance.
// The point walk goes through the single memory read port. A query on an
// empty path skips the walk and answers with a no-path result.
// s_tready is low while a query is in work.
// A result waits in the output register while m_tready is low; loads are
// still taken meanwhile, and the next query result holds in the sequencer
// until the register frees. Reset clears the path, the match index and the
// tolerance register to its default (about 0.01 m^2). The user must write the
// tolerance with cfg_we only while idle; the block does not enforce this.
module path_nearest_point_tracker_core
	import pnpt_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,   // pos_x, pos_y, heading, speed, turn_rate
	input  logic [TUSER_W-1:0]   s_tuser,   // kind, start_new
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata,   // ref_x, ref_y, ref_heading, ref_speed,
	                                        // ref_turn_rate, match_index, zero pad
	output logic [TUSER_W-1:0]   m_tuser,   // no_path, path_too_short
	input  logic                 cfg_we,
	input  logic [TOL_W-1:0]     cfg_wdata
);

	point_t                  in_point, rd_data, out_point_q;
	logic                    wr_en, rd_en, dist_busy, out_free;
	logic [IDX_W-1:0]        wr_addr, rd_addr, out_idx_q;
	dist_tag_t               dist_in_tag, dist_tag;
	logic signed [POS_W-1:0] ax, ay, bx, by;
	logic [DIST_W-1:0]       dist_sum;
	result_ctl_t             res;
	logic                    out_valid_q, out_np_q, out_near_q;

	assign in_point = point_t'(s_tdata);

	pnpt_point_ram u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (in_point),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	pnpt_dist_unit u_dist (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_tag   (dist_in_tag),
		.ax       (ax),
		.ay       (ay),
		.bx       (bx),
		.by       (by),
		.out_tag  (dist_tag),
		.dist_sum (dist_sum),
		.busy     (dist_busy)
	);

	pnpt_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (s_tvalid),
		.in_ready    (s_tready),
		.kind        (s_tuser[0]),
		.start_new   (s_tuser[1]),
		.pos_x       (in_point.x),
		.pos_y       (in_point.y),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.wr_en       (wr_en),
		.wr_addr     (wr_addr),
		.rd_en       (rd_en),
		.rd_addr     (rd_addr),
		.rd_data     (rd_data),
		.dist_in_tag (dist_in_tag),
		.ax          (ax),
		.ay          (ay),
		.bx          (bx),
		.by          (by),
		.dist_tag    (dist_tag),
		.dist_sum    (dist_sum),
		.dist_busy   (dist_busy),
		.out_free    (out_free),
		.res         (res)
	);

	// Output register
	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.load) begin
			out_point_q <= res.no_path ? '0 : rd_data;
			out_idx_q   <= res.idx;
			out_np_q    <= res.no_path;
			out_near_q  <= res.near_ends;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{M_PAD_W{1'b0}}, out_idx_q, out_point_q};
	assign m_tuser  = {out_near_q, out_np_q};

endmodule

FILE: design/pnpt_point_ram.sv
module pnpt_point_ram
	import pnpt_pkg::*;
(
	input  logic             clk,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  point_t           wr_data,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output point_t           rd_data
);

	point_t point_mem [MAX_POINTS];
	point_t rd_data_q;

	// Single write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			point_mem[wr_addr] <= wr_data;
		end
	end

	// Registered read port, holds when idle
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= point_mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

FILE: design/pnpt_dist_unit.sv
module pnpt_dist_unit
	import pnpt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  dist_tag_t               in_tag,
	input  logic signed [POS_W-1:0] ax,
	input  logic signed [POS_W-1:0] ay,
	input  logic signed [POS_W-1:0] bx,
	input  logic signed [POS_W-1:0] by,
	output dist_tag_t               out_tag,
	output logic [DIST_W-1:0]       dist_sum,
	output logic                    busy
);

	logic signed [POS_W:0] diff_x, diff_y;
	logic [POS_W:0]        neg_x, neg_y;
	logic [POS_W-1:0]      dx_s1, dy_s1;
	logic [2*POS_W-1:0]    sqx_s2, sqy_s2;
	dist_tag_t             tag_s1, tag_s2;

	// Absolute coordinate differences
	always_comb begin
		diff_x = {ax[POS_W-1], ax} - {bx[POS_W-1], bx};
		diff_y = {ay[POS_W-1], ay} - {by[POS_W-1], by};
		neg_x  = -diff_x;
		neg_y  = -diff_y;
	end

	always_ff @(posedge clk) begin
		dx_s1  <= diff_x[POS_W] ? neg_x[POS_W-1:0] : diff_x[POS_W-1:0];
		dy_s1  <= diff_y[POS_W] ? neg_y[POS_W-1:0] : diff_y[POS_W-1:0];
		sqx_s2 <= dx_s1 * dx_s1;
		sqy_s2 <= dy_s1 * dy_s1;
	end

	// Tag registers, cleared by reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
			tag_s2 <= '0;
		end else begin
			tag_s1 <= in_tag;
			tag_s2 <= tag_s1;
		end
	end

	// Full-width sum, never overflows
	assign dist_sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};
	assign out_tag  = tag_s2;
	assign busy     = tag_s1.valid | tag_s2.valid;

endmodule

FILE: design/pnpt_ctrl.sv
module pnpt_ctrl
	import pnpt_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	// input transaction
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    kind,
	input  logic                    start_new,
	input  logic signed [POS_W-1:0] pos_x,
	input  logic signed [POS_W-1:0] pos_y,
	// configuration
	input  logic                    cfg_we,
	input  logic [TOL_W-1:0]        cfg_wdata,
	// point memory
	output logic                    wr_en,
	output logic [IDX_W-1:0]        wr_addr,
	output logic                    rd_en,
	output logic [IDX_W-1:0]        rd_addr,
	input  point_t                  rd_data,
	// distance unit
	output dist_tag_t               dist_in_tag,
	output logic signed [POS_W-1:0] ax,
	output logic signed [POS_W-1:0] ay,
	output logic signed [POS_W-1:0] bx,
	output logic signed [POS_W-1:0] by,
	input  dist_tag_t               dist_tag,
	input  logic [DIST_W-1:0]       dist_sum,
	input  logic                    dist_busy,
	// output register
	input  logic                    out_free,
	output result_ctl_t             res
);

	localparam logic [2:0] ST_IDLE     = 3'd0;
	localparam logic [2:0] ST_RD_FIRST = 3'd1;
	localparam logic [2:0] ST_RD_LAST  = 3'd2;
	localparam logic [2:0] ST_SCAN     = 3'd3;
	localparam logic [2:0] ST_DRAIN    = 3'd4;
	localparam logic [2:0] ST_RD_MATCH = 3'd5;
	localparam logic [2:0] ST_RESULT   = 3'd6;
	localparam logic [2:0] ST_EMPTY    = 3'd7;

	logic [2:0]              state_q, state_d;
	logic [CNT_W-1:0]        count_q;
	logic [IDX_W-1:0]        match_q, scan_q, last_addr;
	logic [TOL_W-1:0]        tol_q, best_q;
	logic                    near_q;
	logic signed [POS_W-1:0] pose_x_q, pose_y_q, first_x_q, first_y_q;
	dist_tag_t               iss_tag, iss_tag_s1;
	logic                    not_full, load_acc, query_acc, closer;

	assign not_full  = count_q < CNT_W'(MAX_POINTS);
	assign load_acc  = in_valid && in_ready && (kind == KIND_LOAD);
	assign query_acc = in_valid && in_ready && (kind == KIND_QUERY);
	assign last_addr = IDX_W'(count_q - CNT_W'(1));
	assign wr_addr   = start_new ? '0 : count_q[IDX_W-1:0];
	assign closer    = dist_sum < DIST_W'(best_q);

	// Sequencer
	always_comb begin
		state_d  = state_q;
		in_ready = (state_q == ST_IDLE);
		wr_en    = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		iss_tag  = '0;
		res      = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (load_acc) begin
					wr_en = start_new || not_full;
				end else if (query_acc) begin
					state_d = (count_q == '0) ? ST_EMPTY : ST_RD_FIRST;
				end
			end
			ST_RD_FIRST: begin
				rd_en   = 1'b1;
				state_d = ST_RD_LAST;
			end
			ST_RD_LAST: begin
				rd_en          = 1'b1;
				rd_addr        = last_addr;
				iss_tag.valid  = 1'b1;
				iss_tag.is_end = 1'b1;
				state_d        = ST_SCAN;
			end
			ST_SCAN: begin
				rd_en         = 1'b1;
				rd_addr       = scan_q;
				iss_tag.valid = 1'b1;
				iss_tag.idx   = scan_q;
				if (scan_q == last_addr) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!iss_tag_s1.valid && !dist_busy) begin
					state_d = ST_RD_MATCH;
				end
			end
			ST_RD_MATCH: begin
				rd_en   = 1'b1;
				rd_addr = match_q;
				state_d = ST_RESULT;
			end
			ST_RESULT: begin
				if (out_free) begin
					res.load      = 1'b1;
					res.near_ends = near_q;
					res.idx       = match_q;
					state_d       = ST_IDLE;
				end
			end
			ST_EMPTY: begin
				if (out_free) begin
					res.load    = 1'b1;
					res.no_path = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Distance unit feed: endpoint pair or pose against the stored point
	assign dist_in_tag = iss_tag_s1;
	assign ax          = iss_tag_s1.is_end ? first_x_q : pose_x_q;
	assign ay          = iss_tag_s1.is_end ? first_y_q : pose_y_q;
	assign bx          = rd_data.x;
	assign by          = rd_data.y;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			count_q    <= '0;
			match_q    <= '0;
			tol_q      <= TOL_RESET;
			iss_tag_s1 <= '0;
		end else begin
			state_q    <= state_d;
			iss_tag_s1 <= iss_tag;
			if (cfg_we) begin
				tol_q <= cfg_wdata;
			end
			if (load_acc) begin
				if (start_new) begin
					count_q <= CNT_W'(1);
					match_q <= '0;
				end else if (not_full) begin
					count_q <= count_q + CNT_W'(1);
				end
			end else if (dist_tag.valid && !dist_tag.is_end && closer) begin
				match_q <= dist_tag.idx;
			end
		end
	end

	// Search datapath registers
	always_ff @(posedge clk) begin
		if (query_acc) begin
			pose_x_q <= pos_x;
			pose_y_q <= pos_y;
			best_q   <= SEARCH_BOUND;
			scan_q   <= match_q;
		end
		if (state_q == ST_SCAN) begin
			scan_q <= scan_q + IDX_W'(1);
		end
		if (state_q == ST_RD_LAST) begin
			first_x_q <= rd_data.x;
			first_y_q <= rd_data.y;
		end
		if (dist_tag.valid) begin
			if (dist_tag.is_end) begin
				near_q <= dist_sum <= DIST_W'(tol_q);
			end else if (closer) begin
				best_q <= dist_sum[TOL_W-1:0];
			end
		end
	end

endmodule

FILE: design/pnpt_checker.sv
module pnpt_checker
	import pnpt_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic [TUSER_W-1:0]   s_tuser,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [M_TDATA_W-1:0] m_tdata,
	input logic [TUSER_W-1:0]   m_tuser
);

	// A query transaction occupies the block for at least the next cycle
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == KIND_QUERY) |=> !s_tready)
		else $error("input ready right after a query");

	// A load transaction never blocks the next one
	a_load_fast: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser[0] == KIND_LOAD) |=> s_tready)
		else $error("input ready dropped after a load");

	// A new result only appears while a query is in work
	a_result_from_query: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(!s_tready))
		else $error("result without a query in work");

	// Empty-path results carry an all-zero payload and no near-ends flag
	a_no_path_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tuser[0]) |-> (m_tdata == '0 && !m_tuser[1]))
		else $error("no-path result with nonzero payload");

	// Stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tuser)))
		else $error("stalled result changed");

endmodule

bind path_nearest_point_tracker_core pnpt_checker u_pnpt_checker (.*);
